// ----- design/itco_pkg.sv -----
`default_nettype none
package itco_pkg;

  localparam logic [7:0]  TTL_RESET      = 8'd127;
  localparam logic [7:0]  IPV4_HDR_BYTES = 8'd20;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  VER_IHL        = 8'h45;
  localparam logic [7:0]  DOFF_WORD_IDX  = 8'd6;
  localparam logic [7:0]  CSUM_WORD_IDX  = 8'd8;
  localparam logic [7:0]  WORD_IDX_MAX   = 8'd255;

  // A finished segment handed from the accumulator to the header stage.
  typedef struct packed {
    logic [15:0] seg_sum;
    logic [31:0] src;
    logic [31:0] dst;
    logic [8:0]  seg_len;
    logic [15:0] id;
  } itco_rec_t;

  // End-around carry fold of a sum of up to eight 16-bit terms.
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] a;
    a = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    return a[15:0] + {15'b0, a[16]};
  endfunction

endpackage
`default_nettype wire

// ----- design/itco_seg_acc.sv -----
`default_nettype none
module itco_seg_acc
  import itco_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        acc_i,
  input  wire logic [31:0] source_address_i,
  input  wire logic [31:0] dest_address_i,
  input  wire logic [7:0]  payload_length_i,
  input  wire logic [15:0] segment_word_i,
  input  wire logic        segment_last_i,
  input  wire logic        rec_take_i,
  output logic             rec_valid_o,
  output itco_rec_t        rec_o
);

  logic [15:0] sum_q, sum_d;
  logic [7:0]  idx_q, idx_d;
  logic [5:0]  hb_q, hb_d;
  logic [15:0] cnt_q, cnt_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [7:0]  pay_q, pay_d;
  logic        rec_valid_q, rec_valid_d;
  itco_rec_t   rec_q, rec_d;

  logic [15:0] w;
  logic [8:0]  seg_len;
  logic [15:0] sum_new;
  logic        load_rec;

  assign load_rec = acc_i && segment_last_i;

  always_comb begin
    src_d = src_q;
    dst_d = dst_q;
    pay_d = pay_q;
    if (idx_q == 8'd0) begin
      src_d = source_address_i;
      dst_d = dest_address_i;
      pay_d = payload_length_i;
    end
    hb_d = hb_q;
    if (idx_q == DOFF_WORD_IDX) begin
      hb_d = {segment_word_i[15:12], 2'b00};
    end
    w = (idx_q == CSUM_WORD_IDX) ? 16'h0000 : segment_word_i;
    seg_len = {3'b0, hb_d} + {1'b0, pay_d};
    // An odd segment length leaves a pad byte in the low half of the last word.
    if (segment_last_i && seg_len[0]) begin
      w[7:0] = 8'h00;
    end
    sum_new = oc_fold({3'b0, sum_q} + {3'b0, w});
    sum_d = sum_new;
    idx_d = (idx_q == WORD_IDX_MAX) ? idx_q : idx_q + 8'd1;
    cnt_d = cnt_q;
    rec_d = rec_q;
    if (segment_last_i) begin
      rec_d.seg_sum = sum_new;
      rec_d.src     = src_d;
      rec_d.dst     = dst_d;
      rec_d.seg_len = seg_len;
      rec_d.id      = cnt_q;
      cnt_d = cnt_q + 16'd1;
      sum_d = 16'h0000;
      idx_d = 8'd0;
      hb_d  = 6'd0;
    end
    rec_valid_d = rec_valid_q;
    if (rec_take_i) begin
      rec_valid_d = 1'b0;
    end
    if (load_rec) begin
      rec_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      idx_q       <= '0;
      hb_q        <= '0;
      cnt_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      pay_q       <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      rec_valid_q <= rec_valid_d;
      if (acc_i) begin
        sum_q <= sum_d;
        idx_q <= idx_d;
        hb_q  <= hb_d;
        cnt_q <= cnt_d;
        src_q <= src_d;
        dst_q <= dst_d;
        pay_q <= pay_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rec) begin
      rec_q <= rec_d;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule
`default_nettype wire

// ----- design/itco_hdr_calc.sv -----
`default_nettype none
module itco_hdr_calc
  import itco_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  ttl_i,
  input  wire logic        rec_valid_i,
  input  wire itco_rec_t   rec_i,
  output logic             rec_take_o,
  output logic             out_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      ip_total_len_o,
  output logic [15:0]      ip_ident_o,
  output logic [15:0]      ip_header_checksum_o,
  output logic [15:0]      tcp_checksum_o
);

  logic        valid_q;
  logic [15:0] total_q, id_q, ipsum_q, tsum_q;
  logic [15:0] total_d, ipsum_d, tsum_d;
  logic [18:0] ip_wide, tcp_wide;

  assign out_ready_o = !valid_q || !out_stall_i;
  assign rec_take_o  = rec_valid_i && out_ready_o;

  always_comb begin
    total_d = {7'b0, rec_i.seg_len} + {8'b0, IPV4_HDR_BYTES};
    ip_wide = {3'b0, VER_IHL, 8'h00} + {3'b0, total_d} + {3'b0, rec_i.id}
            + {3'b0, ttl_i, PROTO_TCP}
            + {3'b0, rec_i.src[31:16]} + {3'b0, rec_i.src[15:0]}
            + {3'b0, rec_i.dst[31:16]} + {3'b0, rec_i.dst[15:0]};
    tcp_wide = {3'b0, rec_i.seg_sum}
             + {3'b0, rec_i.src[31:16]} + {3'b0, rec_i.src[15:0]}
             + {3'b0, rec_i.dst[31:16]} + {3'b0, rec_i.dst[15:0]}
             + {11'b0, PROTO_TCP} + {10'b0, rec_i.seg_len};
    ipsum_d = ~oc_fold(ip_wide);
    tsum_d  = ~oc_fold(tcp_wide);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_ready_o) begin
      valid_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      total_q <= total_d;
      id_q    <= rec_i.id;
      ipsum_q <= ipsum_d;
      tsum_q  <= tsum_d;
    end
  end

  assign out_valid_o          = valid_q;
  assign ip_total_len_o       = total_q;
  assign ip_ident_o           = id_q;
  assign ip_header_checksum_o = ipsum_q;
  assign tcp_checksum_o       = tsum_q;

endmodule
`default_nettype wire

// ----- design/ipv4_tcp_checksum_offload.sv -----
`default_nettype none
// TCP/IPv4 transmit checksum offload. The segment (TCP header then payload) streams in
// one big-endian 16-bit word per transfer, at one word per clock unless the input stalls;
// addresses and payload length are sampled with the first word. The running one's
// complement sum is updated in the cycle a word is accepted. One transfer on the output
// follows each word marked last, carrying the IPv4 total length, packet id, IPv4 header
// checksum and TCP checksum. A finished segment waits in a record register and then in
// the output register, so input stalls only when both are full and the output is stalled.
// The TTL register may be written only while no packet is in flight.
module ipv4_tcp_checksum_offload
  import itco_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] source_address_i,
  input  wire logic [31:0] dest_address_i,
  input  wire logic [7:0]  payload_length_i,
  input  wire logic [15:0] segment_word_i,
  input  wire logic        segment_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      ip_total_len_o,
  output logic [15:0]      ip_ident_o,
  output logic [15:0]      ip_header_checksum_o,
  output logic [15:0]      tcp_checksum_o
);

  logic [7:0] ttl_q;
  logic       acc;
  logic       rec_valid;
  logic       rec_take;
  logic       out_ready;
  itco_rec_t  rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TTL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  // The record register frees up in the same cycle the header stage takes it.
  assign in_stall_o = rec_valid && !out_ready;
  assign acc        = in_valid_i && !in_stall_o;

  itco_seg_acc u_acc (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .source_address_i (source_address_i),
    .dest_address_i   (dest_address_i),
    .payload_length_i (payload_length_i),
    .segment_word_i   (segment_word_i),
    .segment_last_i   (segment_last_i),
    .rec_take_i       (rec_take),
    .rec_valid_o      (rec_valid),
    .rec_o            (rec)
  );

  itco_hdr_calc u_hdr (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ttl_i                (ttl_q),
    .rec_valid_i          (rec_valid),
    .rec_i                (rec),
    .rec_take_o           (rec_take),
    .out_ready_o          (out_ready),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .ip_total_len_o       (ip_total_len_o),
    .ip_ident_o           (ip_ident_o),
    .ip_header_checksum_o (ip_header_checksum_o),
    .tcp_checksum_o       (tcp_checksum_o)
  );

endmodule
`default_nettype wire

// ----- design/itco_checker.sv -----
`default_nettype none
module itco_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] ip_total_len_o,
  input wire logic [15:0] ip_ident_o,
  input wire logic [15:0] ip_header_checksum_o,
  input wire logic [15:0] tcp_checksum_o
);

  // A stalled result transfer holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ip_total_len_o)
      && $stable(ip_ident_o) && $stable(ip_header_checksum_o) && $stable(tcp_checksum_o))
    else $error("stalled result changed");

  // The total length covers the IPv4 header and at most a 60-byte TCP header and 255 bytes.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ip_total_len_o >= 16'd20 && ip_total_len_o <= 16'd335)
    else $error("total length out of range");

  // Input backpressure only arises from a full output register.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Input backpressure only arises while the output is stalled.
  a_stall_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

endmodule

bind ipv4_tcp_checksum_offload itco_checker u_itco_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .ip_total_len_o       (ip_total_len_o),
  .ip_ident_o           (ip_ident_o),
  .ip_header_checksum_o (ip_header_checksum_o),
  .tcp_checksum_o       (tcp_checksum_o)
);
`default_nettype wire

// ----- tb/ipv4_tcp_checksum_offload_test.sv -----
module ipv4_tcp_checksum_offload_test;
  import itco_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS   = 190;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  plen;
    logic [15:0] word;
    logic        last;
  } seg_word_t;

  typedef struct packed {
    logic [15:0] total_len;
    logic [15:0] id;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } pkt_fields_t;

  typedef struct packed {
    seg_word_t   item;
    logic        typed;
    pkt_fields_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] source_address_i;
  logic [31:0] dest_address_i;
  logic [7:0]  payload_length_i;
  logic [15:0] segment_word_i;
  logic        segment_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] ip_total_len_o;
  logic [15:0] ip_ident_o;
  logic [15:0] ip_header_checksum_o;
  logic [15:0] tcp_checksum_o;

  ipv4_tcp_checksum_offload dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .source_address_i     (source_address_i),
    .dest_address_i       (dest_address_i),
    .payload_length_i     (payload_length_i),
    .segment_word_i       (segment_word_i),
    .segment_last_i       (segment_last_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .ip_total_len_o       (ip_total_len_o),
    .ip_ident_o           (ip_ident_o),
    .ip_header_checksum_o (ip_header_checksum_o),
    .tcp_checksum_o       (tcp_checksum_o)
  );

  // Shadow state of the checksum engine.
  logic [7:0]  ttl_value;
  logic [15:0] acc_sum;
  logic [7:0]  word_pos;
  logic [5:0]  tcp_hdr_bytes;
  logic [15:0] next_ip_ident;
  logic [31:0] first_src;
  logic [31:0] first_dst;
  logic [7:0]  first_plen;

  pkt_fields_t pending_headers[$];
  int          mismatches;
  int          cycle_count;
  int          words_sent;
  bit          sender_quiet;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic bit offload_step(input seg_word_t it, output pkt_fields_t res);
    logic [15:0] w;
    logic [8:0]  seg_len;
    logic [15:0] total;
    logic [15:0] ip_sum;
    logic [15:0] tcp_sum;
    w   = it.word;
    res = '0;
    if (word_pos == 8'd0) begin
      first_src  = it.src;
      first_dst  = it.dst;
      first_plen = it.plen;
    end
    if (word_pos == DOFF_WORD_IDX) tcp_hdr_bytes = {it.word[15:12], 2'b00};
    // The checksum field itself always counts as zero.
    if (word_pos == CSUM_WORD_IDX) w = '0;
    seg_len = {3'b0, tcp_hdr_bytes} + {1'b0, first_plen};
    if (it.last && seg_len[0]) w[7:0] = '0;
    acc_sum = ones_add(acc_sum, w);
    if (word_pos != WORD_IDX_MAX) word_pos++;
    if (!it.last) return 1'b0;

    total  = {8'b0, IPV4_HDR_BYTES} + {7'b0, seg_len};
    ip_sum = ones_add({VER_IHL, 8'h00}, total);
    ip_sum = ones_add(ip_sum, next_ip_ident);
    ip_sum = ones_add(ip_sum, {ttl_value, PROTO_TCP});
    ip_sum = ones_add(ip_sum, first_src[31:16]);
    ip_sum = ones_add(ip_sum, first_src[15:0]);
    ip_sum = ones_add(ip_sum, first_dst[31:16]);
    ip_sum = ones_add(ip_sum, first_dst[15:0]);

    tcp_sum = ones_add(acc_sum, first_src[31:16]);
    tcp_sum = ones_add(tcp_sum, first_src[15:0]);
    tcp_sum = ones_add(tcp_sum, first_dst[31:16]);
    tcp_sum = ones_add(tcp_sum, first_dst[15:0]);
    tcp_sum = ones_add(tcp_sum, {8'h00, PROTO_TCP});
    tcp_sum = ones_add(tcp_sum, {7'b0, seg_len});

    res = '{total_len: total, id: next_ip_ident, ip_csum: ~ip_sum, tcp_csum: ~tcp_sum};
    next_ip_ident++;
    acc_sum       = '0;
    word_pos      = '0;
    tcp_hdr_bytes = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_word(input seg_word_t it, input bit typed = 1'b0,
                           input pkt_fields_t typed_want = '0);
    int          gap;
    pkt_fields_t res;
    gap = sender_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    source_address_i <= it.src;
    dest_address_i   <= it.dst;
    payload_length_i <= it.plen;
    segment_word_i   <= it.word;
    segment_last_i   <= it.last;
    do @(posedge clk_i); while (in_stall_o);
    if (offload_step(it, res)) pending_headers.push_back(typed ? typed_want : res);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_ttl(input logic [7:0] value);
    in_valid_i <= 1'b0;
    while (pending_headers.size() != 0) @(negedge clk_i);
    // The last result can still be leaving the output register.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ttl_value = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_packet(input bit very_long);
    int        doff;
    int        plen;
    int        nwords;
    int        pick;
    seg_word_t it;
    logic [31:0] src;
    logic [31:0] dst;
    sender_quiet = ($urandom_range(0, 3) == 0);
    pick   = $urandom_range(0, 99);
    plen   = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
    doff   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    nwords = (doff * 4 + plen + 1) / 2;
    if (very_long) begin
      nwords = $urandom_range(256, 300);
    end else if (pick < 8) begin
      // Segment ends before the data offset word is seen.
      nwords = $urandom_range(1, 6);
    end else if (pick < 15) begin
      nwords += $urandom_range(1, 4);
    end else if (pick < 20) begin
      doff   = $urandom_range(0, 4);
      nwords = $urandom_range(7, 24);
    end
    src = $urandom;
    dst = $urandom;
    for (int i = 0; i < nwords; i++) begin
      // Address and length inputs only matter on the first word.
      it.src  = (i == 0) ? src : $urandom;
      it.dst  = (i == 0) ? dst : $urandom;
      it.plen = (i == 0) ? 8'(plen) : 8'($urandom);
      it.word = 16'($urandom);
      if (i == DOFF_WORD_IDX) it.word[15:12] = 4'(doff);
      it.last = (i == nwords - 1);
      send_word(it);
    end
  endtask

  function automatic dir_row_t dir_row(input logic [31:0] src, input logic [31:0] dst,
                                       input logic [7:0] plen, input logic [15:0] word,
                                       input logic last, input logic typed = 1'b0,
                                       input pkt_fields_t want = '0);
    dir_row_t r;
    r.item  = '{src: src, dst: dst, plen: plen, word: word, last: last};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_check
    pkt_fields_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_headers.size() == 0) begin
        report_mismatch($sformatf("result with none pending, ip_ident %h", ip_ident_o));
      end else begin
        want = pending_headers.pop_front();
        compare_field("ip_total_len", ip_total_len_o, want.total_len);
        compare_field("ip_ident", ip_ident_o, want.id);
        compare_field("ip_header_checksum", ip_header_checksum_o, want.ip_csum);
        compare_field("tcp_checksum", tcp_checksum_o, want.tcp_csum);
      end
    end
  end

  initial begin : result_sink
    int hold;
    int served;
    bit quiet;
    served      = 0;
    quiet       = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (served % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
      hold = quiet ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      served++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    dir_row_t    rows[$];
    logic [7:0]  ttl_plan[NUM_PHASES];
    int          phase_start;
    mismatches       = 0;
    cycle_count      = 0;
    words_sent       = 0;
    sender_quiet     = 1'b0;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    source_address_i = '0;
    dest_address_i   = '0;
    payload_length_i = '0;
    segment_word_i   = '0;
    segment_last_i   = 1'b0;
    ttl_value        = TTL_RESET;
    acc_sum          = '0;
    word_pos         = '0;
    tcp_hdr_bytes    = '0;
    next_ip_ident    = '0;
    first_src        = '0;
    first_dst        = '0;
    first_plen       = '0;
    ttl_plan         = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd127};
    ttl_plan[4]      = 8'($urandom);

    // One-word packet of zeros, then one of all ones with an odd length.
    rows.push_back(dir_row(32'h0, 32'h0, 8'd0, 16'h0000, 1'b1, 1'b1,
                           '{16'h0014, 16'h0000, 16'h3be5, 16'hfff9}));
    rows.push_back(dir_row(32'hffffffff, 32'hffffffff, 8'd255, 16'hffff, 1'b1, 1'b1,
                           '{16'h0113, 16'h0001, 16'h3ae5, 16'hfff9}));
    // Full 20-byte header with one payload byte; checksum field holds junk.
    rows.push_back(dir_row(32'hc0a80001, 32'h0a000002, 8'd1, 16'h1f90, 1'b0));
    rows.push_back(dir_row(32'h5a5a5a5a, 32'ha5a5a5a5, 8'd77, 16'h0050, 1'b0));
    rows.push_back(dir_row(32'h12345678, 32'h87654321, 8'd255, 16'h0001, 1'b0));
    rows.push_back(dir_row(32'hffffffff, 32'h00000000, 8'd0, 16'he240, 1'b0));
    rows.push_back(dir_row(32'h00000000, 32'hffffffff, 8'd9, 16'h0000, 1'b0));
    rows.push_back(dir_row(32'hdeadbeef, 32'hcafef00d, 8'd3, 16'h0000, 1'b0));
    rows.push_back(dir_row(32'h0, 32'h0, 8'd0, 16'h5018, 1'b0));
    rows.push_back(dir_row(32'h0, 32'h0, 8'd0, 16'hffff, 1'b0));
    rows.push_back(dir_row(32'h0, 32'h0, 8'd0, 16'hbeef, 1'b0));
    rows.push_back(dir_row(32'h0, 32'h0, 8'd0, 16'h0000, 1'b0));
    rows.push_back(dir_row(32'h0, 32'h0, 8'd0, 16'habcd, 1'b1));
    // Segment shorter than the header, odd length.
    rows.push_back(dir_row(32'h80000000, 32'h00000001, 8'd3, 16'h8001, 1'b0));
    rows.push_back(dir_row(32'h0, 32'h0, 8'd0, 16'h7ffe, 1'b1));
    // Even length: the low byte of the last word is kept.
    rows.push_back(dir_row(32'h0f0f0f0f, 32'hf0f0f0f0, 8'd2, 16'hffff, 1'b1));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_word(rows[i].item, rows[i].typed, rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ttl(ttl_plan[p]);
      phase_start = words_sent;
      if (p == 0) send_random_packet(1'b1);
      while (words_sent - phase_start < PHASE_WORDS) send_random_packet(1'b0);
    end

    in_valid_i <= 1'b0;
    while (pending_headers.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
